FILE: rtl/sct_pkg.sv
// ----------------------------------------------------------------------------
// sct_pkg
// Types and constants shared by the step-chunk queue and step timer.
// ----------------------------------------------------------------------------
package sct_pkg;

  localparam int unsigned CountW    = 16;
  localparam int unsigned IntervalW = 24;
  localparam int unsigned ElapsedW  = 16;
  localparam int unsigned ClockW    = 32;
  localparam int unsigned DepthW    = 6;
  localparam int unsigned ChunkW    = CountW + 2 * IntervalW;

  localparam logic [IntervalW-1:0] IntervalMax = {IntervalW{1'b1}};

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_TICK  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_ESTOP = 2'd3
  } sct_op_e;

  // stored chunk, packed as in the queue memory
  typedef struct packed {
    logic signed [IntervalW-1:0] add;
    logic [IntervalW-1:0]        interval;
    logic [CountW-1:0]           count;
  } sct_chunk_t;

  // queue control to step timer
  typedef struct packed {
    logic tick;
    logic hold;
    logic drop;
    logic avail;
  } sct_tmr_ctl_t;

  // step timer to queue control
  typedef struct packed {
    logic              load;
    logic              step;
    logic              running;
    logic [ClockW-1:0] steps_total;
  } sct_tmr_sts_t;

endpackage

FILE: rtl/sct_intf.sv
// ----------------------------------------------------------------------------
// sct_in_if / sct_out_if
// Valid/ready channels carrying command words and result words.
// ----------------------------------------------------------------------------
interface sct_in_if
  import sct_pkg::*;
();
  logic                        valid;
  logic                        ready;
  sct_op_e                     operation;
  logic [CountW-1:0]           chunk_count;
  logic [IntervalW-1:0]        chunk_interval;
  logic signed [IntervalW-1:0] chunk_add;
  logic [ElapsedW-1:0]         elapsed_us;
  logic                        feed_hold;

  modport source (
    output valid, operation, chunk_count, chunk_interval, chunk_add,
           elapsed_us, feed_hold,
    input  ready
  );
  modport sink (
    input  valid, operation, chunk_count, chunk_interval, chunk_add,
           elapsed_us, feed_hold,
    output ready
  );
endinterface

interface sct_out_if
  import sct_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     push_accepted;
  logic                     step_pulse;
  logic signed [ClockW-1:0] step_total;
  logic [DepthW-1:0]        queue_depth;
  logic                     chunk_active;
  logic                     motor_enable;
  logic                     stopped;

  modport source (
    output valid, push_accepted, step_pulse, step_total, queue_depth,
           chunk_active, motor_enable, stopped,
    input  ready
  );
  modport sink (
    input  valid, push_accepted, step_pulse, step_total, queue_depth,
           chunk_active, motor_enable, stopped,
    output ready
  );
endinterface

FILE: rtl/sct_ram.sv
// ----------------------------------------------------------------------------
// sct_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sct_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/sct_timer.sv
// ----------------------------------------------------------------------------
// sct_timer
// Active chunk state, microsecond interval check and interval update.
// ----------------------------------------------------------------------------
module sct_timer
  import sct_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sct_tmr_ctl_t        ctl_i,
  input  logic [ElapsedW-1:0] elapsed_i,
  input  sct_chunk_t          chunk_i,
  output sct_tmr_sts_t        sts_o
);

  logic                        running_q, running_d;
  logic                        pend_q, pend_d;
  logic [CountW-1:0]           left_q, left_d;
  logic [IntervalW-1:0]        intv_q, intv_d;
  logic signed [IntervalW-1:0] chg_q, chg_d;
  logic [ClockW-1:0]           since_q, since_d;
  logic [ClockW-1:0]           done_q, done_d;

  logic [CountW-1:0]           eff_left;
  logic [IntervalW-1:0]        eff_intv;
  logic signed [IntervalW-1:0] eff_chg;
  logic [ClockW-1:0]           since_sum;
  logic                        due;
  logic signed [IntervalW+1:0] intv_sum;
  logic [CountW-1:0]           left_dec;
  logic                        load, step;

  // chunk fields arrive from the queue memory in the cycle after the load
  assign eff_left = pend_q ? chunk_i.count    : left_q;
  assign eff_intv = pend_q ? chunk_i.interval : intv_q;
  assign eff_chg  = pend_q ? chunk_i.add      : chg_q;

  assign since_sum = since_q + ClockW'(elapsed_i);
  assign due       = !since_sum[ClockW-1] && (since_sum >= ClockW'(eff_intv));
  assign intv_sum  = $signed({2'b00, eff_intv}) + (IntervalW+2)'(eff_chg);
  assign left_dec  = (eff_left != '0) ? eff_left - 1'b1 : eff_left;

  always_comb begin
    running_d = running_q;
    pend_d    = 1'b0;
    left_d    = eff_left;
    intv_d    = eff_intv;
    chg_d     = eff_chg;
    since_d   = since_q;
    done_d    = done_q;
    load      = 1'b0;
    step      = 1'b0;
    if (ctl_i.drop) begin
      running_d = 1'b0;
    end else if (ctl_i.tick) begin
      since_d = since_sum;
      if (!ctl_i.hold) begin
        if (!running_q) begin
          if (ctl_i.avail) begin
            load      = 1'b1;
            running_d = 1'b1;
            pend_d    = 1'b1;
            since_d   = '0;
          end
        end else if (due) begin
          step    = 1'b1;
          since_d = since_sum - ClockW'(eff_intv);
          done_d  = done_q + 1'b1;
          left_d  = left_dec;
          if (intv_sum < $signed((IntervalW+2)'(1))) begin
            intv_d = IntervalW'(1);
          end else if (intv_sum > $signed({2'b00, IntervalMax})) begin
            intv_d = IntervalMax;
          end else begin
            intv_d = intv_sum[IntervalW-1:0];
          end
          running_d = (left_dec != '0);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      pend_q    <= 1'b0;
      left_q    <= '0;
      intv_q    <= '0;
      chg_q     <= '0;
      since_q   <= '0;
      done_q    <= '0;
    end else begin
      running_q <= running_d;
      pend_q    <= pend_d;
      left_q    <= left_d;
      intv_q    <= intv_d;
      chg_q     <= chg_d;
      since_q   <= since_d;
      done_q    <= done_d;
    end
  end

  assign sts_o.load        = load;
  assign sts_o.step        = step;
  assign sts_o.running     = running_d;
  assign sts_o.steps_total = done_d;

endmodule

FILE: rtl/stepper_chunk_queue_step_timer.sv
// ----------------------------------------------------------------------------
// stepper_chunk_queue_step_timer
// Ring queue of step chunks feeding a microsecond step timer.
// ----------------------------------------------------------------------------
// Channel  Dir  Word
// in_i     in   operation, chunk_count, chunk_interval, chunk_add,
//               elapsed_us, feed_hold
// out_o    out  push_accepted, step_pulse, step_total, queue_depth,
//               chunk_active, motor_enable, stopped
//
// One word in, one result word out; a word goes input register -> logic ->
// result register, with one word a cycle while the output is not stalled.
// The queue memory read data is registered; a loaded chunk is forwarded
// to the timer in the cycle after its load.
// Reset clears all control state; queue memory contents are not cleared.
// A stalled output holds the result register and backs up into the input.
// ----------------------------------------------------------------------------
module stepper_chunk_queue_step_timer
  import sct_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sct_in_if.sink    in_i,
  sct_out_if.source out_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  // input register
  logic                        in_vld_q;
  sct_op_e                     op_q;
  sct_chunk_t                  chunk_q;
  logic [ElapsedW-1:0]         elapsed_q;
  logic                        hold_q;

  // queue and latch state
  logic [AW-1:0] wr_q, wr_d;
  logic [AW-1:0] rd_q, rd_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic          stop_q, stop_d;
  logic          en_q, en_d;

  // result register
  logic                     out_vld_q;
  logic                     acc_q;
  logic                     pulse_q;
  logic [ClockW-1:0]        total_q;
  logic [DepthW-1:0]        depth_q;
  logic                     active_q;

  logic         fire;
  logic         push_ok;
  logic         ram_we;
  sct_chunk_t   ram_rdata;
  sct_tmr_ctl_t tmr_ctl;
  sct_tmr_sts_t tmr_sts;

  assign fire       = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      op_q             <= in_i.operation;
      chunk_q.count    <= in_i.chunk_count;
      chunk_q.interval <= in_i.chunk_interval;
      chunk_q.add      <= in_i.chunk_add;
      elapsed_q        <= in_i.elapsed_us;
      hold_q           <= in_i.feed_hold;
    end
  end

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ok = (op_q == OP_PUSH) && (cnt_q != AW'(QUEUE_DEPTH - 1));
  assign ram_we  = fire && push_ok;

  assign tmr_ctl.tick  = fire && (op_q == OP_TICK);
  assign tmr_ctl.hold  = hold_q || stop_q;
  assign tmr_ctl.drop  = fire && ((op_q == OP_CLEAR) || (op_q == OP_ESTOP));
  assign tmr_ctl.avail = (cnt_q != '0);

  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    cnt_d  = cnt_q;
    stop_d = stop_q;
    en_d   = en_q;
    if (fire) begin
      case (op_q)
        OP_PUSH: begin
          if (push_ok) begin
            wr_d  = next_slot(wr_q);
            cnt_d = cnt_q + 1'b1;
          end
        end
        OP_TICK: begin
          if (tmr_sts.load) begin
            rd_d  = next_slot(rd_q);
            cnt_d = cnt_q - 1'b1;
          end
        end
        OP_CLEAR: begin
          rd_d  = wr_q;
          cnt_d = '0;
        end
        OP_ESTOP: begin
          rd_d   = wr_q;
          cnt_d  = '0;
          stop_d = 1'b1;
          en_d   = 1'b0;
        end
        default: begin
          cnt_d = cnt_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q      <= '0;
      rd_q      <= '0;
      cnt_q     <= '0;
      stop_q    <= 1'b0;
      en_q      <= 1'b1;
      out_vld_q <= 1'b0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      cnt_q  <= cnt_d;
      stop_q <= stop_d;
      en_q   <= en_d;
      if (fire) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      acc_q    <= push_ok;
      pulse_q  <= tmr_sts.step;
      total_q  <= tmr_sts.steps_total;
      depth_q  <= DepthW'(cnt_d);
      active_q <= tmr_sts.running;
    end
  end

  sct_ram #(
    .Width (ChunkW),
    .Depth (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_q),
    .wdata_i (chunk_q),
    .raddr_i (rd_q),
    .rdata_o (ram_rdata)
  );

  sct_timer u_timer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (tmr_ctl),
    .elapsed_i (elapsed_q),
    .chunk_i   (ram_rdata),
    .sts_o     (tmr_sts)
  );

  assign out_o.valid         = out_vld_q;
  assign out_o.push_accepted = acc_q;
  assign out_o.step_pulse    = pulse_q;
  assign out_o.step_total    = total_q;
  assign out_o.queue_depth   = depth_q;
  assign out_o.chunk_active  = active_q;
  assign out_o.motor_enable  = en_q;
  assign out_o.stopped       = stop_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= AW'(QUEUE_DEPTH - 1))
    else $error("queue count above capacity");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tmr_sts.load |-> (cnt_q != '0) && fire && (op_q == OP_TICK))
    else $error("chunk load from empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tmr_sts.step |-> fire && (op_q == OP_TICK) && !stop_q)
    else $error("step outside a live tick");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (op_q == OP_ESTOP) |=> stop_q && !en_q && (cnt_q == '0) && (rd_q == wr_q))
    else $error("emergency stop did not latch and drop queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_o.ready |=> out_vld_q && $stable(total_q) && $stable(depth_q))
    else $error("result register overwritten while stalled");
`endif

endmodule

FILE: tb/stepper_chunk_queue_step_timer_tb.sv
// ----------------------------------------------------------------------------
// stepper_chunk_queue_step_timer_tb
// Self-checking bench for the step-chunk queue and step timer. A table of
// directed commands opens the run. Random chunk programs with ticks, clears,
// queue fills and an interval saturation run follow. A feed hold then
// carries the longest interval across held ticks to one step, and an
// emergency stop closes the run. Every result word is checked field by
// field against the table's own word or an in-bench model of the queue
// and timer. Random gaps are put on both channels.
// ----------------------------------------------------------------------------
module stepper_chunk_queue_step_timer_tb;
  import sct_pkg::*;

  localparam int unsigned QDepth      = 64;
  localparam int unsigned IdxW        = $clog2(QDepth);
  localparam int unsigned RandomItems = 1450;
  localparam int unsigned PressureAt  = 500;
  localparam int unsigned PressureLen = 200;
  localparam int unsigned HoldTicks   = 64;
  localparam int unsigned MaxReports  = 40;

  typedef struct packed {
    sct_op_e                     op;
    logic [CountW-1:0]           count;
    logic [IntervalW-1:0]        interval;
    logic signed [IntervalW-1:0] add;
    logic [ElapsedW-1:0]         elapsed;
    logic                        hold;
  } cmd_t;

  typedef struct packed {
    logic                     push_ok;
    logic                     pulse;
    logic signed [ClockW-1:0] total;
    logic [DepthW-1:0]        depth;
    logic                     active;
    logic                     enable;
    logic                     stopped;
  } status_t;

  typedef struct packed {
    cmd_t    cmd;
    logic    typed;
    status_t want;
  } row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  sct_in_if  in_if ();
  sct_out_if out_if ();

  stepper_chunk_queue_step_timer #(
    .QUEUE_DEPTH(QDepth)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // queue and timer state as seen from outside
  sct_chunk_t                  q_store [QDepth];
  logic [IdxW-1:0]             q_wr       = '0;
  logic [IdxW-1:0]             q_rd       = '0;
  logic                        t_running  = 1'b0;
  logic [CountW-1:0]           t_left     = '0;
  logic [IntervalW-1:0]        t_interval = '0;
  logic signed [IntervalW-1:0] t_change   = '0;
  logic [ClockW-1:0]           t_clock    = '0;
  logic [ClockW-1:0]           t_stamp    = '0;
  logic [ClockW-1:0]           t_total    = '0;
  logic                        t_stopped  = 1'b0;
  logic                        t_enable   = 1'b1;

  status_t     status_due [$];
  row_t        plan [$];
  bit          no_idle       = 1'b0;
  int unsigned errors        = 0;
  int unsigned words_sent    = 0;
  int unsigned results_seen  = 0;
  int unsigned steps_seen    = 0;
  int unsigned pushes_refused = 0;

  function automatic status_t next_status(input cmd_t c);
    status_t         r;
    logic [IdxW-1:0] nw;
    logic [ClockW-1:0] diff;
    sct_chunk_t      ch;
    int              nxt;
    r  = '0;
    nw = q_wr + 1'b1;
    case (c.op)
      OP_PUSH: begin
        if (nw != q_rd) begin
          ch.count    = c.count;
          ch.interval = c.interval;
          ch.add      = c.add;
          q_store[q_wr] = ch;
          q_wr      = nw;
          r.push_ok = 1'b1;
        end
      end
      OP_TICK: begin
        t_clock = t_clock + ClockW'(c.elapsed);
        if (!c.hold && !t_stopped) begin
          if (!t_running) begin
            if (q_wr != q_rd) begin
              ch         = q_store[q_rd];
              q_rd       = q_rd + 1'b1;
              t_left     = ch.count;
              t_interval = ch.interval;
              t_change   = ch.add;
              t_running  = 1'b1;
              t_stamp    = t_clock;
            end
          end else begin
            diff = t_clock - t_stamp;
            if (!diff[ClockW-1] && diff >= ClockW'(t_interval)) begin
              t_stamp = t_stamp + ClockW'(t_interval);
              t_total = t_total + 1'b1;
              if (t_left != '0) t_left = t_left - 1'b1;
              nxt = int'(t_interval) + int'(t_change);
              if (nxt < 1) nxt = 1;
              if (nxt > int'(IntervalMax)) nxt = int'(IntervalMax);
              t_interval = IntervalW'(nxt);
              if (t_left == '0) t_running = 1'b0;
              r.pulse = 1'b1;
            end
          end
        end
      end
      OP_CLEAR: begin
        q_rd      = q_wr;
        t_running = 1'b0;
      end
      default: begin
        t_stopped = 1'b1;
        q_rd      = q_wr;
        t_running = 1'b0;
        t_enable  = 1'b0;
      end
    endcase
    r.total   = t_total;
    r.depth   = DepthW'(q_wr - q_rd);
    r.active  = t_running;
    r.enable  = t_enable;
    r.stopped = t_stopped;
    return r;
  endfunction

  function automatic cmd_t make_cmd(input sct_op_e op, input int count, input int interval,
                                    input int add, input int elapsed, input bit hold);
    cmd_t c;
    c.op       = op;
    c.count    = CountW'(count);
    c.interval = IntervalW'(interval);
    c.add      = IntervalW'(add);
    c.elapsed  = ElapsedW'(elapsed);
    c.hold     = hold;
    return c;
  endfunction

  function automatic status_t status_of(input bit ok, input bit pulse, input int total,
                                        input int depth, input bit active, input bit en,
                                        input bit stp);
    status_t s;
    s = '{push_ok: ok, pulse: pulse, total: total, depth: DepthW'(depth),
          active: active, enable: en, stopped: stp};
    return s;
  endfunction

  function automatic int srange(input int lo, input int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic cmd_t rand_chunk();
    int count, interval, add, r;
    r = $urandom_range(0, 99);
    count = (r < 70) ? srange(0, 5) : (r < 90) ? srange(0, 40) : srange(0, 65535);
    r = $urandom_range(0, 99);
    interval = (r < 5) ? 0 : (r < 60) ? srange(1, 200) : (r < 90) ? srange(1, 2000) :
               int'($urandom_range(1, 16777215));
    r = $urandom_range(0, 99);
    add = (r < 60) ? srange(-20, 20) : (r < 85) ? srange(-2000, 2000) : int'($urandom);
    return make_cmd(OP_PUSH, count, interval, add, 0, 1'b0);
  endfunction

  function automatic cmd_t rand_tick();
    int elapsed, r;
    r = $urandom_range(0, 99);
    elapsed = (r < 50) ? srange(0, 150) : (r < 80) ? srange(0, 1000) :
              (r < 95) ? srange(0, 65535) : (($urandom_range(0, 1) != 0) ? 65535 : 0);
    return make_cmd(OP_TICK, int'($urandom), int'($urandom), int'($urandom), elapsed,
                    $urandom_range(0, 7) == 0);
  endfunction

  task automatic send_word(input cmd_t c, input bit typed, input status_t want);
    int unsigned gap;
    status_t     s;
    bit          rdy;
    gap = pick_gap();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid          <= 1'b1;
    in_if.operation      <= c.op;
    in_if.chunk_count    <= c.count;
    in_if.chunk_interval <= c.interval;
    in_if.chunk_add      <= c.add;
    in_if.elapsed_us     <= c.elapsed;
    in_if.feed_hold      <= c.hold;
    // ready is settled by the falling edge and holds until the next rising one
    do begin
      @(negedge clk_i);
      rdy = in_if.ready;
      @(posedge clk_i);
    end while (!rdy);
    s = next_status(c);
    if (c.op == OP_PUSH && !s.push_ok) pushes_refused++;
    status_due.push_back(typed ? want : s);
    words_sent++;
  endtask

  task automatic send_free(input cmd_t c);
    send_word(c, 1'b0, '0);
  endtask

  task automatic add_row(input cmd_t c, input bit typed, input status_t want);
    plan.push_back('{cmd: c, typed: typed, want: want});
  endtask

  task automatic play_plan();
    foreach (plan[i]) send_word(plan[i].cmd, plan[i].typed, plan[i].want);
    plan.delete();
  endtask

  task automatic await_drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (status_due.size() != 0);
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MaxReports)
        $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  initial begin : stimulus
    int unsigned base, r, n;
    in_if.valid          <= 1'b0;
    in_if.operation      <= OP_TICK;
    in_if.chunk_count    <= '0;
    in_if.chunk_interval <= '0;
    in_if.chunk_add      <= '0;
    in_if.elapsed_us     <= '0;
    in_if.feed_hold      <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // tick on empty queue, count-zero chunk, extreme chunk, hold, load, step
    add_row(make_cmd(OP_TICK, 0, 0, 0, 0, 1'b0), 1'b1, status_of(0, 0, 0, 0, 0, 1, 0));
    add_row(make_cmd(OP_PUSH, 0, 1, 0, 0, 1'b0), 1'b1, status_of(1, 0, 0, 1, 0, 1, 0));
    add_row(make_cmd(OP_PUSH, 65535, 16777215, -8388608, 0, 1'b0), 1'b1,
            status_of(1, 0, 0, 2, 0, 1, 0));
    add_row(make_cmd(OP_TICK, 0, 0, 0, 5, 1'b1), 1'b1, status_of(0, 0, 0, 2, 0, 1, 0));
    add_row(make_cmd(OP_TICK, 0, 0, 0, 0, 1'b0), 1'b1, status_of(0, 0, 0, 1, 1, 1, 0));
    add_row(make_cmd(OP_TICK, 0, 0, 0, 1, 1'b0), 1'b1, status_of(0, 1, 1, 1, 0, 1, 0));
    add_row(make_cmd(OP_TICK, 0, 0, 0, 65535, 1'b0), 1'b1, status_of(0, 0, 1, 0, 1, 1, 0));
    add_row(make_cmd(OP_TICK, 65535, 16777215, -1, 65535, 1'b0), 1'b0, '0);
    add_row(make_cmd(OP_CLEAR, 0, 0, 0, 0, 1'b0), 1'b1, status_of(0, 0, 1, 0, 0, 1, 0));
    // zero interval: steps at once, then the change lifts it
    add_row(make_cmd(OP_PUSH, 2, 0, 8388607, 0, 1'b0), 1'b1, status_of(1, 0, 1, 1, 0, 1, 0));
    add_row(make_cmd(OP_TICK, 0, 0, 0, 0, 1'b0), 1'b0, '0);
    add_row(make_cmd(OP_TICK, 0, 0, 0, 0, 1'b0), 1'b0, '0);
    add_row(make_cmd(OP_TICK, 0, 0, 0, 65535, 1'b0), 1'b0, '0);
    add_row(make_cmd(OP_PUSH, 1, 1, -8388608, 0, 1'b0), 1'b0, '0);
    add_row(make_cmd(OP_CLEAR, 0, 0, 0, 0, 1'b0), 1'b1, status_of(0, 0, 2, 0, 0, 1, 0));
    // floor at one
    add_row(make_cmd(OP_PUSH, 3, 2, -8388608, 0, 1'b0), 1'b0, '0);
    add_row(make_cmd(OP_TICK, 0, 0, 0, 1, 1'b0), 1'b0, '0);
    add_row(make_cmd(OP_TICK, 0, 0, 0, 2, 1'b0), 1'b0, '0);
    add_row(make_cmd(OP_TICK, 0, 0, 0, 1, 1'b0), 1'b0, '0);
    add_row(make_cmd(OP_TICK, 0, 0, 0, 65535, 1'b0), 1'b0, '0);
    add_row(make_cmd(OP_TICK, 0, 0, 0, 0, 1'b0), 1'b0, '0);
    play_plan();
    await_drain();

    base = words_sent;
    while (words_sent < base + RandomItems) begin
      r = $urandom_range(0, 99);
      if (r < 8) no_idle = !no_idle;
      if (r < 70) begin
        n = $urandom_range(1, 4);
        repeat (n) send_free(rand_chunk());
        n = $urandom_range(1, 20);
        repeat (n) send_free(rand_tick());
      end else if (r < 78) begin
        n = $urandom_range(1, 6);
        repeat (n)
          send_free(make_cmd(sct_op_e'($urandom_range(0, 2)), int'($urandom),
                             int'($urandom), int'($urandom), int'($urandom),
                             $urandom_range(0, 1)));
      end else if (r < 85) begin
        n = $urandom_range(5, 40);
        repeat (n) send_free(rand_tick());
      end else if (r < 90) begin
        send_free(make_cmd(OP_CLEAR, 0, 0, 0, 0, 1'b0));
      end else if (r < 95) begin
        // overfill: later pushes must be refused
        repeat (QDepth + 2) send_free(rand_chunk());
        n = $urandom_range(3, 10);
        repeat (n) send_free(rand_tick());
      end else begin
        // second step drives the interval into saturation
        send_free(make_cmd(OP_CLEAR, 0, 0, 0, 0, 1'b0));
        send_free(make_cmd(OP_PUSH, 2, srange(1, 200), 8388607, 0, 1'b0));
        send_free(make_cmd(OP_TICK, 0, 0, 0, 0, 1'b0));
        send_free(make_cmd(OP_TICK, 0, 0, 0, 200, 1'b0));
        repeat (131) send_free(make_cmd(OP_TICK, 0, 0, 0, 65535, 1'b0));
      end
    end

    // feed hold: time still counts, the longest interval steps once after release
    await_drain();
    no_idle = 1'b1;
    send_free(make_cmd(OP_CLEAR, 0, 0, 0, 0, 1'b0));
    send_free(make_cmd(OP_PUSH, 1, 16777215, 0, 0, 1'b0));
    send_free(make_cmd(OP_TICK, 0, 0, 0, 0, 1'b0));
    repeat (HoldTicks) send_free(make_cmd(OP_TICK, 0, 0, 0, 65535, 1'b1));
    repeat (200) send_free(make_cmd(OP_TICK, 0, 0, 0, 65535, 1'b0));
    no_idle = 1'b0;

    // emergency stop last: it latches until reset
    add_row(make_cmd(OP_PUSH, 1, 3, 0, 0, 1'b0), 1'b0, '0);
    add_row(make_cmd(OP_TICK, 0, 0, 0, 0, 1'b0), 1'b0, '0);
    add_row(make_cmd(OP_ESTOP, 0, 0, 0, 0, 1'b0), 1'b0, '0);
    add_row(make_cmd(OP_PUSH, 4, 1, 1, 0, 1'b0), 1'b0, '0);
    add_row(make_cmd(OP_TICK, 0, 0, 0, 100, 1'b0), 1'b0, '0);
    add_row(make_cmd(OP_CLEAR, 0, 0, 0, 0, 1'b0), 1'b0, '0);
    add_row(make_cmd(OP_TICK, 0, 0, 0, 7, 1'b0), 1'b0, '0);
    play_plan();

    await_drain();
    repeat (8) @(posedge clk_i);
    $display("Run covered %0d command words, %0d result words, %0d steps, %0d pushes refused.",
             words_sent, results_seen, steps_seen, pushes_refused);
    $display("Included queue overfill, interval floor and saturation, feed hold and emergency stop.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : result_sink
    int unsigned stall_left;
    bit          take;
    status_t     got;
    status_t     want;
    stall_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      // handshake and word are settled by the falling edge
      @(negedge clk_i);
      take = out_if.valid && out_if.ready;
      got  = {out_if.push_accepted, out_if.step_pulse, out_if.step_total,
              out_if.queue_depth, out_if.chunk_active, out_if.motor_enable,
              out_if.stopped};
      @(posedge clk_i);
      if (take) begin
        results_seen++;
        if (got.pulse) steps_seen++;
        if (status_due.size() == 0) begin
          errors++;
          if (errors <= MaxReports)
            $display("%0t: result word with none expected, got %0h", $time, got);
        end else begin
          want = status_due.pop_front();
          check_field("push_accepted", want.push_ok, got.push_ok);
          check_field("step_pulse", want.pulse, got.pulse);
          check_field("step_total", want.total, got.total);
          check_field("queue_depth", want.depth, got.depth);
          check_field("chunk_active", want.active, got.active);
          check_field("motor_enable", want.enable, got.enable);
          check_field("stopped", want.stopped, got.stopped);
        end
        // one long back-pressure stretch while the sender keeps offering
        stall_left = (results_seen == PressureAt) ? PressureLen : pick_gap();
      end
      if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin : run_limit
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
